@@ rtl/poc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poc_pkg: shared definitions for the perturb-and-observe charge controller
// widths, reset values, opcode, phase and register codes, duty step helpers
// ----------------------------------------------------------------------------
package poc_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int DUTY_BITS   = 9;
    localparam int STEP_BITS   = 6;
    localparam int POWER_BITS  = 2 * SAMPLE_BITS;
    localparam int CFG_BITS    = (SAMPLE_BITS > DUTY_BITS) ? SAMPLE_BITS : DUTY_BITS;
    localparam int CFG_IDX_BITS = 3;

    // reset values of the configuration registers
    localparam logic [STEP_BITS-1:0]   STEP_RST       = STEP_BITS'(5);
    localparam logic [DUTY_BITS-1:0]   HIGH_LIMIT_RST = DUTY_BITS'(498);
    localparam logic [DUTY_BITS-1:0]   LOW_LIMIT_RST  = DUTY_BITS'(50);
    localparam logic [DUTY_BITS-1:0]   MAINT_DUTY_RST = DUTY_BITS'(250);
    localparam logic [SAMPLE_BITS-1:0] FULL_THRESH_RST = SAMPLE_BITS'(646);
    localparam logic [DUTY_BITS-1:0]   START_DUTY_RST = DUTY_BITS'(260);

    // item opcodes
    localparam logic [1:0] OP_PANEL   = 2'd0;
    localparam logic [1:0] OP_BATTERY = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // phase codes as seen on the result port
    localparam logic [1:0] PHASE_CODE_UP    = 2'd0;
    localparam logic [1:0] PHASE_CODE_DOWN  = 2'd1;
    localparam logic [1:0] PHASE_CODE_CHECK = 2'd2;
    localparam logic [1:0] PHASE_CODE_MAINT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP        = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAINT_DUTY  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_THRESH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_DUTY  = 3'd5;

    typedef enum logic [3:0] {
        PH_UP    = 4'b0001,
        PH_DOWN  = 4'b0010,
        PH_CHECK = 4'b0100,
        PH_MAINT = 4'b1000
    } phase_t;

    // up step, refused if it would reach the high limit
    function automatic logic [DUTY_BITS-1:0] step_up(
        input logic [DUTY_BITS-1:0] d,
        input logic [STEP_BITS-1:0] step,
        input logic [DUTY_BITS-1:0] high
    );
        logic [DUTY_BITS:0] t;
        t = {1'b0, d} + (DUTY_BITS + 1)'(step);
        return (t >= {1'b0, high}) ? d : t[DUTY_BITS-1:0];
    endfunction

    // down step, refused if it would fall to the low limit or below
    function automatic logic [DUTY_BITS-1:0] step_down(
        input logic [DUTY_BITS-1:0] d,
        input logic [STEP_BITS-1:0] step,
        input logic [DUTY_BITS-1:0] low
    );
        logic [DUTY_BITS:0] lim;
        lim = {1'b0, low} + (DUTY_BITS + 1)'(step);
        return ({1'b0, d} <= lim) ? d : (d - DUTY_BITS'(step));
    endfunction

endpackage
`default_nettype wire

@@ rtl/perturb_observe_charge_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// perturb_observe_charge_controller: solar charge controller, pwm duty output
// perturb-and-observe tracking with up and down trials, tick-started battery
// checks and a fixed maintenance duty once the battery is full
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     in_valid/in_ready    opcode, panel_current, panel_voltage,
//                                 battery_voltage
//  result    out_valid/out_ready  duty, phase, battery_full, sample_ignored
//  config    cfg_write            cfg_index, cfg_data (no handshake, no read)
//
//  an accepted item is held in the input register, then passes through the
//  multiply, compare and duty step logic into the result register. a new
//  item is taken every cycle while results drain.
//  a stalled result holds both stages; in_ready drops only when the input
//  register is full and cannot move on.
//  reset is asynchronous, active low; config registers return to defaults.
//
module perturb_observe_charge_controller (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [poc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [poc_pkg::CFG_BITS-1:0]      cfg_data,
    // input items
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        opcode,
    input  wire logic [poc_pkg::SAMPLE_BITS-1:0]   panel_current,
    input  wire logic [poc_pkg::SAMPLE_BITS-1:0]   panel_voltage,
    input  wire logic [poc_pkg::SAMPLE_BITS-1:0]   battery_voltage,
    // result items
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [poc_pkg::DUTY_BITS-1:0]          duty,
    output logic [1:0]                             phase,
    output logic                                   battery_full,
    output logic                                   sample_ignored
);
    import poc_pkg::*;

    // configuration registers
    // start duty only matters at reset, which loads its default, so a write
    // to it has no lasting effect and is not stored
    logic [STEP_BITS-1:0]   step_reg;
    logic [DUTY_BITS-1:0]   high_limit_reg;
    logic [DUTY_BITS-1:0]   low_limit_reg;
    logic [DUTY_BITS-1:0]   maint_duty_reg;
    logic [SAMPLE_BITS-1:0] full_thresh_reg;

    // controller state
    logic [DUTY_BITS-1:0]   base_duty_reg,  base_duty_next;
    phase_t                 phase_reg,      phase_next;
    logic [POWER_BITS-1:0]  up_power_reg,   up_power_next;
    logic                   pending_reg,    pending_next;
    logic                   full_reg,       full_next;

    // input stage
    logic                   s1_valid_reg;
    logic [1:0]             s1_opcode_reg;
    logic [SAMPLE_BITS-1:0] s1_current_reg;
    logic [SAMPLE_BITS-1:0] s1_voltage_reg;
    logic [SAMPLE_BITS-1:0] s1_battery_reg;

    // result stage
    logic                   out_valid_reg;
    logic [DUTY_BITS-1:0]   duty_reg,       duty_next;
    logic [1:0]             phase_code_reg, phase_code_next;
    logic                   full_out_reg;
    logic                   ignored_reg,    ignored_next;

    logic                   in_fire;
    logic                   out_advance;
    logic                   s1_fire;
    logic [POWER_BITS-1:0]  power;
    logic [DUTY_BITS-1:0]   duty_up;
    logic [DUTY_BITS-1:0]   duty_down;
    logic [DUTY_BITS-1:0]   duty_down2;

    // ---------------------------------------------------------------- handshake
    // result register frees up when empty or being taken this cycle
    assign out_advance = !out_valid_reg || out_ready;
    assign s1_fire     = s1_valid_reg && out_advance;
    assign in_ready    = !s1_valid_reg || out_advance;
    assign in_fire     = in_valid && in_ready;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= STEP_RST;
            high_limit_reg  <= HIGH_LIMIT_RST;
            low_limit_reg   <= LOW_LIMIT_RST;
            maint_duty_reg  <= MAINT_DUTY_RST;
            full_thresh_reg <= FULL_THRESH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STEP:        step_reg        <= cfg_data[STEP_BITS-1:0];
                CFG_HIGH_LIMIT:  high_limit_reg  <= cfg_data[DUTY_BITS-1:0];
                CFG_LOW_LIMIT:   low_limit_reg   <= cfg_data[DUTY_BITS-1:0];
                CFG_MAINT_DUTY:  maint_duty_reg  <= cfg_data[DUTY_BITS-1:0];
                CFG_FULL_THRESH: full_thresh_reg <= cfg_data[SAMPLE_BITS-1:0];
                default:         ; // start duty and unused indexes
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    // trial power, and the three possible steps of the base duty in parallel
    assign power      = POWER_BITS'(s1_current_reg) * POWER_BITS'(s1_voltage_reg);
    assign duty_up    = step_up(base_duty_reg, step_reg, high_limit_reg);
    assign duty_down  = step_down(base_duty_reg, step_reg, low_limit_reg);
    assign duty_down2 = step_down(duty_down, step_reg, low_limit_reg);

    always_comb
    begin
        base_duty_next = base_duty_reg;
        phase_next     = phase_reg;
        up_power_next  = up_power_reg;
        pending_next   = pending_reg;
        full_next      = full_reg;
        ignored_next   = 1'b0;

        case (s1_opcode_reg)
            OP_PANEL:
            begin
                if (phase_reg == PH_UP)
                begin
                    up_power_next = power;
                    phase_next    = PH_DOWN;
                end
                else if (phase_reg == PH_DOWN)
                begin
                    // strictly more power on the down trial: two steps down
                    base_duty_next = (power > up_power_reg) ? duty_down2 : duty_up;
                    // end of round: serve a pending tick
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        phase_next   = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_UP;
                    end
                end
                else
                begin
                    ignored_next = 1'b1;
                end
            end
            OP_BATTERY:
            begin
                if (phase_reg == PH_CHECK)
                begin
                    full_next = (s1_battery_reg >= full_thresh_reg);
                    if (s1_battery_reg >= full_thresh_reg)
                    begin
                        base_duty_next = maint_duty_reg;
                        phase_next     = PH_MAINT;
                    end
                    else
                    begin
                        phase_next = PH_UP;
                    end
                end
                else
                begin
                    ignored_next = 1'b1;
                end
            end
            OP_TICK:
            begin
                // in maintenance the check starts at once
                if (phase_reg == PH_MAINT)
                    phase_next = PH_CHECK;
                else
                    pending_next = 1'b1;
            end
            default:
            begin
                ignored_next = 1'b1;
            end
        endcase

        // drive the duty that belongs to the new phase
        case (phase_next)
            PH_UP:
            begin
                duty_next       = step_up(base_duty_next, step_reg, high_limit_reg);
                phase_code_next = PHASE_CODE_UP;
            end
            PH_DOWN:
            begin
                duty_next       = step_down(base_duty_next, step_reg, low_limit_reg);
                phase_code_next = PHASE_CODE_DOWN;
            end
            PH_CHECK:
            begin
                duty_next       = '0;
                phase_code_next = PHASE_CODE_CHECK;
            end
            default:
            begin
                duty_next       = base_duty_next;
                phase_code_next = PHASE_CODE_MAINT;
            end
        endcase
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_duty_reg <= START_DUTY_RST;
            phase_reg     <= PH_UP;
            up_power_reg  <= '0;
            pending_reg   <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // state moves only as an item passes into the result register
            if (s1_fire)
            begin
                base_duty_reg <= base_duty_next;
                phase_reg     <= phase_next;
                up_power_reg  <= up_power_next;
                pending_reg   <= pending_next;
                full_reg      <= full_next;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg  <= opcode;
            s1_current_reg <= panel_current;
            s1_voltage_reg <= panel_voltage;
            s1_battery_reg <= battery_voltage;
        end
        if (s1_fire)
        begin
            duty_reg       <= duty_next;
            phase_code_reg <= phase_code_next;
            full_out_reg   <= full_next;
            ignored_reg    <= ignored_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duty           = duty_reg;
    assign phase          = phase_code_reg;
    assign battery_full   = full_out_reg;
    assign sample_ignored = ignored_reg;

endmodule
`default_nettype wire
